>>> sv/bdbd_pkg.sv
// Shared types, codes and constants of the best detection box decoder.
`default_nettype none
package bdbd_pkg;

    localparam int LARGE_GRID_DEF   = 32;
    localparam int SMALL_GRID_DEF   = 16;
    localparam int ANCHOR_SLOTS_DEF = 3;

    localparam int NUM_ANCHORS = 6;
    localparam int ANCHOR_IW   = 3;

    localparam logic [2:0] CFG_THRESH  = 3'd0;
    localparam logic [2:0] CFG_IMG     = 3'd1;
    localparam logic [2:0] CFG_ANCHOR0 = 3'd2;

    localparam logic signed [15:0] THRESH_RST = 16'sd64;
    localparam logic [12:0]        IMG_RST    = 13'd512;
    localparam logic [15:0]        ANCHOR_RST [NUM_ANCHORS] =
        '{16'd3598, 16'd4112, 16'd4626, 16'd5397, 16'd6682, 16'd8995};

    localparam logic [ANCHOR_IW-1:0] ANCHOR_BASE_LARGE = 3'd3;

    localparam int DIV_W  = 64;
    localparam int DIV_QW = 25;
    localparam int DIV_CW = $clog2(DIV_QW);

    localparam logic signed [33:0] LOG2E_Q16 = 34'sd94548;
    localparam logic [31:0]        EXP_C3    = 32'd5115;
    localparam logic [15:0]        EXP_C2    = 16'd14838;
    localparam logic [15:0]        EXP_C1    = 16'd45580;
    localparam logic [16:0]        EXP_ONE   = 17'h10000;

    localparam logic [9:0]  SHIFT_ZERO = 10'd26;
    localparam logic [9:0]  SHIFT_SAT  = 10'd24;
    localparam logic [22:0] SIZE_MAX   = 23'h7FFFFF;

    typedef struct packed {
        logic               head;
        logic [1:0]         anchor_slot;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] log_width;
        logic signed [15:0] log_height;
        logic signed [15:0] objectness;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [22:0]        box_width;
        logic [22:0]        box_height;
        logic signed [15:0] score;
    } t_out_item;

    typedef struct packed {
        logic track;
        logic pass;
        logic c_start;
        logic c_store;
        logic z_en;
        logic p1_en;
        logic p2_en;
        logic p3_en;
        logic n_en;
        logic sz_start;
        logic sz_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic div_done;
    } t_status;

    typedef enum logic [3:0] {
        S_TRACK,
        S_CHECK,
        S_C_LD,
        S_C_RUN,
        S_Z,
        S_P1,
        S_P2,
        S_P3,
        S_N,
        S_SZ_LD,
        S_SZ_RUN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> sv/bdbd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bdbd_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bdbd_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [bdbd_pkg::DIV_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [bdbd_pkg::DIV_QW-1:0]      o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [bdbd_pkg::DIV_CW-1:0]  r_cnt;
    logic [bdbd_pkg::DIV_W-1:0]   r_rem;
    logic [bdbd_pkg::DIV_W-1:0]   r_dvs;
    logic [bdbd_pkg::DIV_QW-1:0]  r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= i_divisor << (bdbd_pkg::DIV_QW - 1);
            r_cnt <= bdbd_pkg::DIV_CW'(bdbd_pkg::DIV_QW - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[bdbd_pkg::DIV_QW-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[bdbd_pkg::DIV_QW-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

>>> sv/bdbd_dpath.sv
// Datapath: config registers, best-cell tracking, box decode arithmetic, result register.
`default_nettype none
module bdbd_dpath #(
    parameter int LARGE_GRID   = bdbd_pkg::LARGE_GRID_DEF,
    parameter int SMALL_GRID   = bdbd_pkg::SMALL_GRID_DEF,
    parameter int ANCHOR_SLOTS = bdbd_pkg::ANCHOR_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bdbd_pkg::t_cmd      i_cmd,
    output bdbd_pkg::t_status        o_status,
    input  wire bdbd_pkg::t_in_item  i_in_data,
    input  wire logic                i_cfg_valid,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output bdbd_pkg::t_out_item      o_out_data
);

    localparam logic signed [26:0] LG = 27'(LARGE_GRID);
    localparam logic signed [26:0] SG = 27'(SMALL_GRID);
    localparam logic [1:0] SLOT_MAX = 2'((ANCHOR_SLOTS - 1 > 2) ? 2 : ANCHOR_SLOTS - 1);
    localparam logic [30:0] RECIP_L =
        31'(((64'd1 << 32) + 64'(2 * LARGE_GRID) - 64'd1) / 64'(2 * LARGE_GRID));
    localparam logic [30:0] RECIP_S =
        31'(((64'd1 << 32) + 64'(2 * SMALL_GRID) - 64'd1) / 64'(2 * SMALL_GRID));

    logic signed [15:0]   r_thresh;
    logic [12:0]          r_img;
    logic [15:0]          r_anchor [bdbd_pkg::NUM_ANCHORS];

    logic                 r_valid;
    bdbd_pkg::t_in_item   r_best;

    logic                 r_c_neg;
    logic [24:0]          r_c_mag;
    logic signed [23:0]   r_cx;
    logic signed [23:0]   r_cy;
    logic signed [25:0]   r_z;
    logic [31:0]          r_acc;
    logic [24:0]          r_nprod;
    logic                 r_sz_zero;
    logic                 r_sz_sat;
    logic [22:0]          r_bw;
    logic [22:0]          r_bh;
    bdbd_pkg::t_out_item  r_out;

    logic                 found;
    logic [4:0]           c_idx;
    logic signed [15:0]   c_off;
    logic signed [26:0]   c_grid;
    logic signed [26:0]   c_n;
    logic signed [26:0]   c_num;
    logic                 c_neg;
    logic [26:0]          c_mag;
    logic [30:0]          c_recip;
    logic [55:0]          c_prod;
    logic [23:0]          c_quo;

    logic signed [15:0]   z_log;
    logic signed [33:0]   z_prod;
    logic [15:0]          e_f;
    logic [15:0]          e_p1;
    logic [15:0]          e_p2;
    logic [16:0]          e_m;
    logic [1:0]           a_slot;
    logic [bdbd_pkg::ANCHOR_IW-1:0] a_idx;
    logic [15:0]          a_pair;
    logic [7:0]           a_val;

    logic [9:0]           k_u;
    logic [9:0]           neg_k;
    logic                 k_neg;
    logic                 s_far;
    logic                 s_zero;
    logic                 s_sat;
    logic [4:0]           sh_num;
    logic [4:0]           sh_den;
    logic [12:0]          img_eff;
    logic [bdbd_pkg::DIV_W-1:0] s_num;
    logic [bdbd_pkg::DIV_W-1:0] s_den;

    logic                 div_start;
    logic                 div_done;
    logic [bdbd_pkg::DIV_W-1:0]  div_dvd;
    logic [bdbd_pkg::DIV_W-1:0]  div_dvs;
    logic [bdbd_pkg::DIV_QW-1:0] q;
    logic signed [23:0]   c_res;
    logic [22:0]          sz_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= bdbd_pkg::THRESH_RST;
            r_img    <= bdbd_pkg::IMG_RST;
            for (int i = 0; i < bdbd_pkg::NUM_ANCHORS; i++) begin
                r_anchor[i] <= bdbd_pkg::ANCHOR_RST[i];
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bdbd_pkg::CFG_THRESH: begin
                    r_thresh <= i_cfg_data;
                end
                bdbd_pkg::CFG_IMG: begin
                    r_img <= i_cfg_data[12:0];
                end
                default: begin
                    r_anchor[i_cfg_index - bdbd_pkg::CFG_ANCHOR0] <= i_cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b0;
        end else if (i_cmd.track) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.track && (!r_valid || (i_in_data.objectness > r_best.objectness))) begin
            r_best <= i_in_data;
        end
    end

    assign found = r_best.objectness >= r_thresh;

    always_comb begin
        c_idx  = i_cmd.pass ? r_best.row : r_best.col;
        c_off  = i_cmd.pass ? r_best.offset_y : r_best.offset_x;
        c_grid = r_best.head ? SG : LG;
        c_n    = $signed({14'd0, c_idx, 8'd0}) + 27'(c_off);
        c_num  = (c_n <<< 9) + c_grid;
        c_neg  = c_num[26];
        c_mag  = c_neg ? $unsigned(-c_num + (c_grid <<< 1) - 27'sd1) : $unsigned(c_num);
    end

    always_comb begin
        z_log  = i_cmd.pass ? r_best.log_height : r_best.log_width;
        z_prod = 34'(z_log) * bdbd_pkg::LOG2E_Q16;
        e_f    = r_z[15:0];
        e_p1   = 16'(r_acc[28:16]) + bdbd_pkg::EXP_C2;
        e_p2   = r_acc[31:16] + bdbd_pkg::EXP_C1;
        e_m    = {1'b0, r_acc[31:16]} + bdbd_pkg::EXP_ONE;
        a_slot = (r_best.anchor_slot > SLOT_MAX) ? SLOT_MAX : r_best.anchor_slot;
        a_idx  = r_best.head ? {1'b0, a_slot} : bdbd_pkg::ANCHOR_BASE_LARGE + {1'b0, a_slot};
        a_pair = r_anchor[a_idx];
        a_val  = i_cmd.pass ? a_pair[15:8] : a_pair[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.z_en) begin
            r_z <= z_prod[33:8];
        end
        if (i_cmd.p1_en) begin
            r_acc <= bdbd_pkg::EXP_C3 * {16'd0, e_f};
        end
        if (i_cmd.p2_en) begin
            r_acc <= {16'd0, e_p1} * {16'd0, e_f};
        end
        if (i_cmd.p3_en) begin
            r_acc <= {16'd0, e_p2} * {16'd0, e_f};
        end
        if (i_cmd.n_en) begin
            r_nprod <= {8'd0, e_m} * {17'd0, a_val};
        end
    end

    always_comb begin
        k_u     = r_z[25:16];
        k_neg   = k_u[9];
        neg_k   = 10'd0 - k_u;
        s_far   = k_neg && (neg_k >= bdbd_pkg::SHIFT_ZERO);
        s_zero  = (r_nprod == '0) || s_far;
        s_sat   = !k_neg && (k_u >= bdbd_pkg::SHIFT_SAT);
        sh_num  = (!k_neg && !s_sat) ? k_u[4:0] : 5'd0;
        sh_den  = (k_neg && !s_far) ? neg_k[4:0] : 5'd0;
        img_eff = (r_img == '0) ? 13'd1 : r_img;
        s_num   = {39'd0, r_nprod} << sh_num;
        s_den   = {51'd0, img_eff} << sh_den;
    end

    assign div_start = i_cmd.sz_start;
    assign div_dvd   = s_num + (s_den >> 1);
    assign div_dvs   = s_den;

    bdbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.c_start) begin
            r_c_neg <= c_neg;
            r_c_mag <= c_mag[24:0];
        end
        if (i_cmd.sz_start) begin
            r_sz_zero <= s_zero;
            r_sz_sat  <= s_sat;
        end
    end

    always_comb begin
        c_recip = r_best.head ? RECIP_S : RECIP_L;
        c_prod  = {31'd0, r_c_mag} * {25'd0, c_recip};
        c_quo   = c_prod[55:32];
        c_res   = r_c_neg ? $signed(24'd0 - c_quo) : $signed(c_quo);
        if (r_sz_zero) begin
            sz_res = '0;
        end else if (r_sz_sat || q[24] || q[23]) begin
            sz_res = bdbd_pkg::SIZE_MAX;
        end else begin
            sz_res = q[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.c_store) begin
            if (i_cmd.pass) begin
                r_cy <= c_res;
            end else begin
                r_cx <= c_res;
            end
        end
        if (i_cmd.sz_store) begin
            if (i_cmd.pass) begin
                r_bh <= sz_res;
            end else begin
                r_bw <= sz_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (found) begin
                r_out.found      <= 1'b1;
                r_out.center_x   <= r_cx;
                r_out.center_y   <= r_cy;
                r_out.box_width  <= r_bw;
                r_out.box_height <= r_bh;
                r_out.score      <= r_best.objectness;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_status.found    = found;
    assign o_status.div_done = div_done;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

>>> sv/bdbd_ctrl.sv
// Controller: frame tracking, decode sequencing and result handshake.
`default_nettype none
module bdbd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire bdbd_pkg::t_status  i_status,
    output bdbd_pkg::t_cmd          o_cmd
);

    bdbd_pkg::t_state r_state;
    bdbd_pkg::t_state n_state;
    logic             r_pass;
    logic             n_pass;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdbd_pkg::S_TRACK;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.pass  = r_pass;
        case (r_state)
            bdbd_pkg::S_TRACK: begin
                if (i_in_valid) begin
                    o_cmd.track = 1'b1;
                    if (i_in_last) begin
                        n_state = bdbd_pkg::S_CHECK;
                    end
                end
            end
            bdbd_pkg::S_CHECK: begin
                n_pass  = 1'b0;
                n_state = i_status.found ? bdbd_pkg::S_C_LD : bdbd_pkg::S_DONE;
            end
            bdbd_pkg::S_C_LD: begin
                o_cmd.c_start = 1'b1;
                n_state       = bdbd_pkg::S_C_RUN;
            end
            bdbd_pkg::S_C_RUN: begin
                o_cmd.c_store = 1'b1;
                n_pass        = !r_pass;
                n_state       = r_pass ? bdbd_pkg::S_Z : bdbd_pkg::S_C_LD;
            end
            bdbd_pkg::S_Z: begin
                o_cmd.z_en = 1'b1;
                n_state    = bdbd_pkg::S_P1;
            end
            bdbd_pkg::S_P1: begin
                o_cmd.p1_en = 1'b1;
                n_state     = bdbd_pkg::S_P2;
            end
            bdbd_pkg::S_P2: begin
                o_cmd.p2_en = 1'b1;
                n_state     = bdbd_pkg::S_P3;
            end
            bdbd_pkg::S_P3: begin
                o_cmd.p3_en = 1'b1;
                n_state     = bdbd_pkg::S_N;
            end
            bdbd_pkg::S_N: begin
                o_cmd.n_en = 1'b1;
                n_state    = bdbd_pkg::S_SZ_LD;
            end
            bdbd_pkg::S_SZ_LD: begin
                o_cmd.sz_start = 1'b1;
                n_state        = bdbd_pkg::S_SZ_RUN;
            end
            bdbd_pkg::S_SZ_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.sz_store = 1'b1;
                    n_pass         = !r_pass;
                    n_state        = r_pass ? bdbd_pkg::S_DONE : bdbd_pkg::S_Z;
                end
            end
            bdbd_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = bdbd_pkg::S_TRACK;
                end
            end
            default: begin
                n_state = bdbd_pkg::S_TRACK;
            end
        endcase
    end

    assign o_in_stall  = (r_state != bdbd_pkg::S_TRACK);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_last) |=> o_in_stall)
        else $error("last cell did not stall the input");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == bdbd_pkg::S_C_RUN ||
                               r_state == bdbd_pkg::S_SZ_RUN))
        else $error("divider finished outside a run state");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && !o_in_stall))
        else $error("result load did not raise valid and reopen input");
`endif

endmodule
`default_nettype wire

>>> sv/best_detection_box_decode_core.sv
// Top level of the best detection box decoder.
// Cells are taken one per cycle while a frame is tracked; input stalls from the last cell
// until the result loads. The result request is valid after decode, or after the threshold
// check when the best score is below threshold, later while a previous result is held.
// Each size: exp steps, divider load, serial divide; each centre: load and store.
// Reset is synchronous, active low: config returns to defaults, tracking and output valid clear.
`default_nettype none
module best_detection_box_decode_core #(
    parameter int LARGE_GRID   = bdbd_pkg::LARGE_GRID_DEF,
    parameter int SMALL_GRID   = bdbd_pkg::SMALL_GRID_DEF,
    parameter int ANCHOR_SLOTS = bdbd_pkg::ANCHOR_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire bdbd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bdbd_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    bdbd_pkg::t_cmd    cmd;
    bdbd_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bdbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bdbd_dpath #(
        .LARGE_GRID   (LARGE_GRID),
        .SMALL_GRID   (SMALL_GRID),
        .ANCHOR_SLOTS (ANCHOR_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
